[hw/rtl/swi_pkg.sv]
// Shared types and constants for the station width interpolator.
// Holds the transaction payload structs and the table entry layout; no dependencies.
package swi_pkg;

	localparam int STATION_W = 24;
	localparam int WIDTH_W   = 16;
	localparam int PROD_W    = STATION_W + WIDTH_W;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int STEP_W    = $clog2(WIDTH_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RIGHT = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [INDEX_W-1:0]   entry_index;
		logic [STATION_W-1:0] entry_station;
		logic [WIDTH_W-1:0]   entry_left_width;
		logic [WIDTH_W-1:0]   entry_right_width;
		logic [STATION_W-1:0] query_station;
	} in_item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] left_wd;
		logic [WIDTH_W-1:0] right_wd;
		logic               used_default;
	} out_item_t;

	typedef struct packed {
		logic [STATION_W-1:0] station;
		logic [WIDTH_W-1:0]   left;
		logic [WIDTH_W-1:0]   right;
	} entry_t;

endpackage

[hw/rtl/station_width_interpolator_top.sv]
// Station width interpolator: table lookup with linear interpolation between sections.
// Writes go straight to the table; an empty-table query gives the defaults in the cycle
// after accept; other queries read entries in turn up to the hit or last valid entry, and
// interpolating ones pass PREP, MUL, LOAD and the dividers. One transaction at a time.
// Reset clears control, config and result state; datapath and table start undefined.
// Depends on swi_pkg, swi_table_mem and swi_divider.
module station_width_interpolator_top #(
	parameter int MAX_SECTIONS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  swi_pkg::in_item_t               item,
	output logic                            result_valid,
	output swi_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swi_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);
	localparam int SW = swi_pkg::STATION_W;
	localparam int WW = swi_pkg::WIDTH_W;
	localparam int PW = swi_pkg::PROD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_MUL,
		ST_LOAD,
		ST_WAIT
	} state_t;

	state_t state_q;

	logic [swi_pkg::COUNT_W-1:0] count_q;
	logic [WW-1:0]               def_left_q;
	logic [WW-1:0]               def_right_q;

	logic [CW-1:0]               n_eff;
	logic [CW-1:0]               n_q;
	logic [AW-1:0]               i_q;
	logic [SW-1:0]               query_q;

	swi_pkg::out_item_t          result_q;
	logic                        result_valid_q;

	swi_pkg::entry_t             prev_q;
	swi_pkg::entry_t             lo_q;
	swi_pkg::entry_t             hi_q;
	logic [SW-1:0]               num_q;
	logic [SW-1:0]               den_q;
	logic [WW-1:0]               dl_q;
	logic [WW-1:0]               dr_q;
	logic                        up_l_q;
	logic                        up_r_q;
	logic [PW-1:0]               prod_l_q;
	logic [PW-1:0]               prod_r_q;
	logic [PW-1:0]               prod_l;
	logic [PW-1:0]               prod_r;

	logic                        accept;
	logic                        wr_en;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	swi_pkg::entry_t             wr_data;
	swi_pkg::entry_t             rd_data;
	logic                        hit_ge;
	logic                        hit_last;
	logic                        div_start;
	logic [WW-1:0]               quo_l;
	logic [WW-1:0]               quo_r;
	logic                        div_done_l;
	logic                        div_done_r;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			def_left_q  <= '0;
			def_right_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				swi_pkg::CFG_SECTION_COUNT: count_q     <= cfg_data[swi_pkg::COUNT_W-1:0];
				swi_pkg::CFG_DEFAULT_LEFT:  def_left_q  <= cfg_data[WW-1:0];
				swi_pkg::CFG_DEFAULT_RIGHT: def_right_q <= cfg_data[WW-1:0];
				default: ;
			endcase
		end
	end

	// clamp the section count to the table depth
	assign n_eff = (32'(count_q) > MAX_SECTIONS) ? CW'(MAX_SECTIONS) : CW'(count_q);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign wr_en   = accept && (item.cmd == swi_pkg::CMD_WRITE) &&
	                 (32'(item.entry_index) < MAX_SECTIONS);
	assign wr_data = '{station: item.entry_station,
	                   left:    item.entry_left_width,
	                   right:   item.entry_right_width};

	assign hit_ge   = rd_data.station >= query_q;
	assign hit_last = CW'(i_q) == (n_q - 1'b1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q + 1'b1;
		if (state_q == ST_IDLE) begin
			rd_addr = '0;
			rd_en   = accept && (item.cmd == swi_pkg::CMD_QUERY) && (n_eff != '0);
		end else if (state_q == ST_SCAN) begin
			rd_en = !hit_ge && !hit_last;
		end
	end

	swi_table_mem #(
		.DEPTH (MAX_SECTIONS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(item.entry_index)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign div_start = (state_q == ST_LOAD);

	swi_divider u_div_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_l_q),
		.divisor  (den_q),
		.quotient (quo_l),
		.done     (div_done_l)
	);

	swi_divider u_div_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_r_q),
		.divisor  (den_q),
		.quotient (quo_r),
		.done     (div_done_r)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			i_q            <= '0;
			n_q            <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.cmd == swi_pkg::CMD_QUERY)) begin
						if (n_eff == '0) begin
							result_q       <= '{left_wd:      def_left_q,
							                    right_wd:     def_right_q,
							                    used_default: 1'b1};
							result_valid_q <= 1'b1;
						end else begin
							n_q     <= n_eff;
							i_q     <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit_ge && (i_q != '0)) begin
						state_q <= ST_PREP;
					end else if (hit_ge || hit_last) begin
						// first entry hit, or no entry qualifies: clamp
						result_q       <= '{left_wd:      rd_data.left,
						                    right_wd:     rd_data.right,
						                    used_default: 1'b0};
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_PREP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done_l && div_done_r) begin
						result_q       <= '{left_wd:      up_l_q ? lo_q.left + quo_l
						                                         : lo_q.left - quo_l,
						                    right_wd:     up_r_q ? lo_q.right + quo_r
						                                         : lo_q.right - quo_r,
						                    used_default: 1'b0};
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign prod_l = dl_q * num_q;
	assign prod_r = dr_q * num_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= item.query_station;
		end
		if (state_q == ST_SCAN) begin
			prev_q <= rd_data;
			if (hit_ge) begin
				lo_q <= prev_q;
				hi_q <= rd_data;
			end
		end
		if (state_q == ST_PREP) begin
			num_q  <= query_q - lo_q.station;
			den_q  <= hi_q.station - lo_q.station;
			up_l_q <= hi_q.left >= lo_q.left;
			up_r_q <= hi_q.right >= lo_q.right;
			dl_q   <= (hi_q.left >= lo_q.left) ? hi_q.left - lo_q.left
			                                   : lo_q.left - hi_q.left;
			dr_q   <= (hi_q.right >= lo_q.right) ? hi_q.right - lo_q.right
			                                     : lo_q.right - hi_q.right;
		end
		if (state_q == ST_MUL) begin
			prod_l_q <= prod_l;
			prod_r_q <= prod_r;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

[hw/rtl/swi_table_mem.sv]
// Section table memory: one write port, one read port with registered read data.
// Depends on swi_pkg for the entry layout.
module swi_table_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  swi_pkg::entry_t      wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output swi_pkg::entry_t      rd_data
);

	swi_pkg::entry_t mem [DEPTH];
	swi_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/swi_divider.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation quotient.
// The dividend must be below divisor * 2^WIDTH_W. Depends on swi_pkg.
module swi_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [swi_pkg::PROD_W-1:0]    dividend,
	input  logic [swi_pkg::STATION_W-1:0] divisor,
	output logic [swi_pkg::WIDTH_W-1:0]   quotient,
	output logic                          done
);

	localparam int SW = swi_pkg::STATION_W;
	localparam int WW = swi_pkg::WIDTH_W;

	logic                         run_q;
	logic                         done_q;
	logic [swi_pkg::STEP_W-1:0]   cnt_q;
	logic [SW-1:0]                rem_q;
	logic [WW-1:0]                low_q;
	logic [WW-1:0]                quo_q;
	logic [SW-1:0]                div_q;
	logic [SW:0]                  trial;
	logic [SW:0]                  diff;
	logic                         fits;

	assign trial = {rem_q, low_q[WW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= swi_pkg::STEP_W'(WW - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[swi_pkg::PROD_W-1:WW];
			low_q <= dividend[WW-1:0];
			div_q <= divisor;
		end else if (run_q) begin
			// partial remainder stays below the divisor, so it fits SW bits
			rem_q <= fits ? diff[SW-1:0] : trial[SW-1:0];
			low_q <= {low_q[WW-2:0], 1'b0};
			quo_q <= {quo_q[WW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[sim/station_width_interpolator_top_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for station_width_interpolator_top: table writes, queries, register writes.
// Depends on swi_pkg and station_width_interpolator_top; predicts every query result on its own.
module station_width_interpolator_top_test;
	import swi_pkg::*;

	localparam int TBL_DEPTH   = 64;
	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEM_TARGET = 1900;
	localparam logic [STATION_W-1:0] STA_MAX = '1;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 busy;
	in_item_t             item        = '0;
	logic                 result_valid;
	out_item_t            result;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_SECTION_COUNT;
	logic [CFG_DAT_W-1:0] cfg_data    = '0;

	// Predicted block state
	logic [STATION_W-1:0] tbl_station [TBL_DEPTH];
	logic [WIDTH_W-1:0]   tbl_left    [TBL_DEPTH];
	logic [WIDTH_W-1:0]   tbl_right   [TBL_DEPTH];
	logic [COUNT_W-1:0]   sect_count  = '0;
	logic [WIDTH_W-1:0]   def_left    = '0;
	logic [WIDTH_W-1:0]   def_right   = '0;

	// Stimulus side
	in_item_t             cmd_queue [$];
	out_item_t            width_fifo [$];
	logic [STATION_W-1:0] plan_sta [TBL_DEPTH];
	int unsigned          issued      = 0;
	int unsigned          taken       = 0;
	int unsigned          gap_left    = 0;
	int unsigned          burst_left  = 1;
	int unsigned          idle_cycles = 0;
	int unsigned          item_total  = 0;
	int                   fail_count  = 0;

	station_width_interpolator_top #(
		.MAX_SECTIONS(TBL_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [WIDTH_W-1:0] lerp_width(input logic [WIDTH_W-1:0] wlo,
			input logic [WIDTH_W-1:0] whi, input logic [STATION_W-1:0] num,
			input logic [STATION_W-1:0] den);
		logic [WIDTH_W-1:0] diff;
		logic [PROD_W-1:0]  quo;
		diff = (whi >= wlo) ? whi - wlo : wlo - whi;
		quo  = (PROD_W'(diff) * PROD_W'(num)) / PROD_W'(den);
		return (whi >= wlo) ? wlo + quo[WIDTH_W-1:0] : wlo - quo[WIDTH_W-1:0];
	endfunction

	function automatic out_item_t query_widths(input logic [STATION_W-1:0] q);
		int        n;
		int        hit;
		bit        found;
		out_item_t r;
		n     = (sect_count > TBL_DEPTH) ? TBL_DEPTH : int'(sect_count);
		found = 1'b0;
		r     = '0;
		if (n == 0) begin
			r.left_wd      = def_left;
			r.right_wd     = def_right;
			r.used_default = 1'b1;
			return r;
		end
		hit = n - 1;
		for (int i = 0; i < n; i++) begin
			if (!found && tbl_station[i] >= q) begin
				hit   = i;
				found = 1'b1;
			end
		end
		if (!found || hit == 0) begin
			r.left_wd  = tbl_left[hit];
			r.right_wd = tbl_right[hit];
		end else begin
			r.left_wd  = lerp_width(tbl_left[hit-1], tbl_left[hit], q - tbl_station[hit-1],
				tbl_station[hit] - tbl_station[hit-1]);
			r.right_wd = lerp_width(tbl_right[hit-1], tbl_right[hit], q - tbl_station[hit-1],
				tbl_station[hit] - tbl_station[hit-1]);
		end
		return r;
	endfunction

	function automatic logic [WIDTH_W-1:0] rand_width();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return WIDTH_W'($urandom);
			end
		endcase
	endfunction

	task automatic queue_entry_write(input int unsigned idx, input logic [STATION_W-1:0] sta,
			input logic [WIDTH_W-1:0] lw, input logic [WIDTH_W-1:0] rw);
		in_item_t it;
		it.cmd               = CMD_WRITE;
		it.entry_index       = INDEX_W'(idx);
		it.entry_station     = sta;
		it.entry_left_width  = lw;
		it.entry_right_width = rw;
		it.query_station     = STATION_W'($urandom);
		plan_sta[idx]        = sta;
		cmd_queue            = {cmd_queue, it};
		item_total++;
	endtask

	task automatic queue_query(input logic [STATION_W-1:0] q);
		in_item_t it;
		it.cmd               = CMD_QUERY;
		it.entry_index       = INDEX_W'($urandom);
		it.entry_station     = STATION_W'($urandom);
		it.entry_left_width  = WIDTH_W'($urandom);
		it.entry_right_width = WIDTH_W'($urandom);
		it.query_station     = q;
		cmd_queue            = {cmd_queue, it};
		item_total++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_SECTION_COUNT: begin
				sect_count = val[COUNT_W-1:0];
			end
			CFG_DEFAULT_LEFT: begin
				def_left = val;
			end
			CFG_DEFAULT_RIGHT: begin
				def_right = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold until everything sent has been taken and answered, then let a write finish.
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || issued != taken || width_fifo.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Driver: bursts of transactions separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!start || taken == issued)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (cmd_queue.size() > 0) begin
				item  <= cmd_queue.pop_front();
				start <= 1'b1;
				issued++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results, predict on accepted transactions, watch for a hang.
	always @(posedge clk) begin
		out_item_t exp_w;
		bit        moved;
		moved = 1'b0;
		if (arst_n && result_valid) begin
			moved = 1'b1;
			if (width_fifo.size() == 0) begin
				$error("result with no query outstanding: left_wd %0h right_wd %0h",
					result.left_wd, result.right_wd);
				fail_count++;
			end else begin
				exp_w = width_fifo.pop_front();
				if (result.left_wd !== exp_w.left_wd) begin
					$error("left_wd: expected %0h, actual %0h",
						exp_w.left_wd, result.left_wd);
					fail_count++;
				end
				if (result.right_wd !== exp_w.right_wd) begin
					$error("right_wd: expected %0h, actual %0h",
						exp_w.right_wd, result.right_wd);
					fail_count++;
				end
				if (result.used_default !== exp_w.used_default) begin
					$error("used_default: expected %0b, actual %0b",
						exp_w.used_default, result.used_default);
					fail_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			moved = 1'b1;
			taken++;
			if (item.cmd == CMD_QUERY) begin
				width_fifo = {width_fifo, query_widths(item.query_station)};
			end else begin
				tbl_station[item.entry_index] = item.entry_station;
				tbl_left[item.entry_index]    = item.entry_left_width;
				tbl_right[item.entry_index]   = item.entry_right_width;
			end
		end
		if (cfg_valid && cfg_ready)
			moved = 1'b1;
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned n_cfg;
		int unsigned n;
		int unsigned nq;
		int unsigned kind;
		int unsigned step;
		int unsigned sta;
		int unsigned q;
		int unsigned lo;
		int unsigned hi;
		bit          unsorted;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table straight out of reset: defaults are zero.
		queue_query('0);
		queue_query(STA_MAX);
		// Writes go in regardless of the count.
		queue_entry_write(0, 24'h000100, 16'h0000, 16'hFFFF);
		queue_entry_write(1, 24'h001000, 16'hFFFF, 16'h0000);
		queue_entry_write(2, 24'h800000, 16'h1234, 16'hFEDC);
		queue_entry_write(3, STA_MAX, 16'hFFFF, 16'hFFFF);
		queue_entry_write(TBL_DEPTH - 1, STA_MAX, 16'hAAAA, 16'h5555);
		wait_idle();
		write_reg(CFG_DEFAULT_LEFT, 16'hFFFF);
		write_reg(CFG_DEFAULT_RIGHT, 16'h0000);
		queue_query(24'h123456);
		wait_idle();
		// Below the first, on an entry, between entries, at the top station.
		write_reg(CFG_SECTION_COUNT, 16'd4);
		queue_query('0);
		queue_query(24'h000100);
		queue_query(24'h000101);
		queue_query(24'h000800);
		queue_query(24'h001000);
		queue_query(24'h001001);
		queue_query(24'h7FFFFF);
		queue_query(24'h800000);
		queue_query(24'hFFFFFE);
		queue_query(STA_MAX);
		wait_idle();
		// Past the last valid entry: clamp to it.
		write_reg(CFG_SECTION_COUNT, 16'd3);
		queue_query(STA_MAX);
		queue_query(24'h800001);
		wait_idle();
		write_reg(CFG_SECTION_COUNT, 16'd1);
		queue_query('0);
		queue_query(STA_MAX);

		// Random phases: full table first, then an oversized count over an unsorted table.
		for (int phase = 0; item_total < ITEM_TARGET; phase++) begin
			kind = $urandom_range(0, 19);
			if (phase == 0)
				n_cfg = TBL_DEPTH;
			else if (phase == 1 || kind == 3)
				n_cfg = $urandom_range(TBL_DEPTH + 1, (1 << COUNT_W) - 1);
			else if (kind < 2)
				n_cfg = 0;
			else if (kind == 2)
				n_cfg = TBL_DEPTH;
			else if (kind < 12)
				n_cfg = $urandom_range(1, 8);
			else
				n_cfg = $urandom_range(1, TBL_DEPTH - 1);
			n = (n_cfg > TBL_DEPTH) ? TBL_DEPTH : n_cfg;
			unsorted = (phase == 1) || ($urandom_range(0, 4) == 0);

			wait_idle();
			write_reg(CFG_SECTION_COUNT, CFG_DAT_W'(n_cfg));
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_DEFAULT_LEFT, rand_width());
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_DEFAULT_RIGHT, rand_width());

			case ($urandom_range(0, 4))
				0: step = 1;
				1: step = 16;
				2: step = 256;
				3: step = 4096;
				default: step = 262143;
			endcase
			sta = $urandom_range(0, 16'hFFFF);
			// Fill every valid slot before the first query reads it.
			for (int i = 0; i < n; i++) begin
				if (unsorted) begin
					queue_entry_write(i, STATION_W'($urandom), rand_width(), rand_width());
				end else begin
					queue_entry_write(i, STATION_W'(sta), rand_width(), rand_width());
					sta = sta + $urandom_range(0, step);
					if (sta > STA_MAX)
						sta = STA_MAX;
				end
			end

			nq = $urandom_range(4, 40);
			for (int j = 0; j < nq; j++) begin
				if (n < TBL_DEPTH && $urandom_range(0, 9) == 0)
					queue_entry_write($urandom_range(n, TBL_DEPTH - 1), STATION_W'($urandom),
						rand_width(), rand_width());
				kind = (n == 0) ? 0 : $urandom_range(0, 9);
				q = $urandom_range(0, STA_MAX);
				if (kind >= 3 && kind <= 5) begin
					q = plan_sta[$urandom_range(0, n - 1)];
					case ($urandom_range(0, 2))
						0: if (q != 0) q = q - 1;
						2: if (q != STA_MAX) q = q + 1;
						default: ;
					endcase
				end else if ((kind == 6 || kind == 7) && n >= 2) begin
					hi = $urandom_range(1, n - 1);
					lo = plan_sta[hi - 1];
					hi = plan_sta[hi];
					q  = (lo < hi) ? $urandom_range(lo, hi) : hi;
				end else if (kind == 8) begin
					q = plan_sta[n - 1] + $urandom_range(1, 1000);
					if (q > STA_MAX)
						q = STA_MAX;
				end else if (kind == 9) begin
					q = ($urandom_range(0, 1) == 0) ? 0 : STA_MAX;
				end
				queue_query(STATION_W'(q));
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (width_fifo.size() != 0) begin
			$error("%0d query results never arrived", width_fifo.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[station_width_interpolator_top.f]
hw/rtl/swi_pkg.sv
hw/rtl/swi_table_mem.sv
hw/rtl/swi_divider.sv
hw/rtl/station_width_interpolator_top.sv
sim/station_width_interpolator_top_test.sv
